// ===== rtl/ltbs_pkg.sv =====
// Shared types and constants of the lit texel block shader.
// Stream beat layouts, request kinds and the configuration register map.
// Depends on nothing.
`default_nettype none

package ltbs_pkg;

    // Kind of an input beat, carried on s_tuser.
    typedef enum logic
    {
        REQ_MAP_WRITE = 1'b0,
        REQ_SHADE     = 1'b1
    } req_type_t;

    // Field widths that the stream layout fixes.
    localparam int LIGHT_W   = 16;
    localparam int CORNER_W  = 14;
    localparam int INDEX_W   = 14;
    localparam int BYTE_W    = 8;
    localparam int TEXELS_W  = 64;
    localparam int ROW_W     = 5;
    localparam int SHIFT_W   = 3;
    localparam int MIP_W     = 2;

    // Input tdata layout, lowest bit first.
    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + INDEX_W;
    localparam int BLK_LSB   = VAL_LSB + BYTE_W;
    localparam int TL_LSB    = BLK_LSB + 1;
    localparam int TR_LSB    = TL_LSB + CORNER_W;
    localparam int BL_LSB    = TR_LSB + CORNER_W;
    localparam int BR_LSB    = BL_LSB + CORNER_W;
    localparam int TXL_LSB   = BR_LSB + CORNER_W;
    localparam int TXH_LSB   = TXL_LSB + TEXELS_W;
    localparam int S_FIELDS_W = TXH_LSB + TEXELS_W;
    localparam int S_TDATA_W = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 2 * TEXELS_W;

    // Configuration port.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] LOD_SEL_ADDR = 2'd0;

endpackage

`default_nettype wire

// ===== rtl/ltbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameters set word width and depth. Depends on nothing.
`default_nettype none

module ltbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lit_texel_block_shader.sv =====
// Lit texel block shader: shades one texture block row per beat through a colormap.
// Depends on ltbs_pkg and ltbs_ram.
//
// Use of the block:
// The input stream (s_*) carries two kinds of beat, told apart by s_tuser.
// A colormap write stores map_value at map_index and gives no output beat.
// A shade beat gives one output beat (m_*) with sixteen pixel bytes and
// m_tlast set on the last row of a block. The first row of a block has
// block_start set and brings the four corner lights.
// APB address 0 holds the level of detail select, which sets the block size to
// MAX_BLOCK_TEXELS shifted right by it. Write it only while idle (not enforced).
// Throughput: one beat per clock cycle in either kind while the skid register
// is empty. Each lane has its own copy of the colormap, so all texels of a row
// are looked up in the same cycle; a colormap write goes to every copy at once.
// A shade beat passes two pipeline stages, then the colormap read with pixel
// assembly, then the output register, before it shows on m_tvalid.
// Reset clears the edge lights, steps, row count and the level of detail
// select; the colormap contents are undefined until written.
// When the receiver stalls, one result is caught in a skid register and
// s_tready falls in the next cycle until the skid register drains.
`default_nettype none

module lit_texel_block_shader #(
    parameter int MAX_BLOCK_TEXELS = 16,
    parameter int LIGHT_LEVELS     = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ltbs_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ltbs_pkg::APB_DATA_W-1:0]    pwdata,
    output      logic [ltbs_pkg::APB_DATA_W-1:0]    prdata,
    output      logic                               pready,
    // Input stream
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    // map_index[13:0], map_value[21:14], block_start[22], light_top_left[36:23],
    // light_top_right[50:37], light_bottom_left[64:51], light_bottom_right[78:65],
    // texels_low[142:79], texels_high[206:143], zero pad[207]
    input  wire logic [ltbs_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type[0]
    input  wire logic                               s_tuser,
    // Output stream
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    // pixels_low[63:0], pixels_high[127:64]
    output      logic [ltbs_pkg::M_TDATA_W-1:0]     m_tdata,
    // last_row
    output      logic                               m_tlast
);

    localparam int LANES   = MAX_BLOCK_TEXELS;
    localparam int LVL_W   = $clog2(LIGHT_LEVELS);
    localparam int ADDR_W  = LVL_W + ltbs_pkg::BYTE_W;
    localparam int DEPTH   = LIGHT_LEVELS * 256;
    localparam int LW      = ltbs_pkg::LIGHT_W;
    localparam int RW      = ltbs_pkg::ROW_W;
    localparam int TXW     = 2 * ltbs_pkg::TEXELS_W;
    localparam logic [11:0] LEVELS_12 = 12'(LIGHT_LEVELS);

    // Block size for a mip level, kept between 1 and 16.
    function automatic logic [RW-1:0] block_size(input logic [ltbs_pkg::MIP_W-1:0] m);
        int v;
        v = MAX_BLOCK_TEXELS >> m;
        if (v < 1)
        begin
            v = 1;
        end
        if (v > 16)
        begin
            v = 16;
        end
        return RW'(v);
    endfunction

    // Floor of log2 of the block size.
    function automatic logic [ltbs_pkg::SHIFT_W-1:0] block_shift(input logic [RW-1:0] b);
        logic [ltbs_pkg::SHIFT_W-1:0] s;
        s = '0;
        for (int i = 1; i < RW; i++)
        begin
            if ((b >> i) != '0)
            begin
                s = ltbs_pkg::SHIFT_W'(i);
            end
        end
        return s;
    endfunction

    // Light level modulo LIGHT_LEVELS by restoring subtraction; the value
    // is below sixteen times the level count, so four steps suffice.
    function automatic logic [LVL_W-1:0] level_mod(input logic [7:0] x);
        logic [11:0] r;
        r = {4'b0000, x};
        for (int i = 3; i >= 0; i--)
        begin
            if (r >= (LEVELS_12 << i))
            begin
                r = r - (LEVELS_12 << i);
            end
        end
        return r[LVL_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [ltbs_pkg::MIP_W-1:0] mip_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ltbs_pkg::LOD_SEL_ADDR);
    assign prdata = (paddr == ltbs_pkg::LOD_SEL_ADDR)
                    ? {{(ltbs_pkg::APB_DATA_W-ltbs_pkg::MIP_W){1'b0}}, mip_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mip_reg <= '0;
        end
        else if (cfg_wr)
        begin
            mip_reg <= pwdata[ltbs_pkg::MIP_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Input decode and edge light state
    // ---------------------------------------------------------------
    logic                          en;
    logic                          acc;
    logic                          is_shade;
    logic                          blk;
    logic [ltbs_pkg::CORNER_W-1:0] tl, tr, bl, br;
    logic [RW-1:0]                 bs;
    logic [ltbs_pkg::SHIFT_W-1:0]  sh;

    logic [LW-1:0] left_light_reg,  left_light_next;
    logic [LW-1:0] right_light_reg, right_light_next;
    logic [LW-1:0] left_step_reg,   left_step_next;
    logic [LW-1:0] right_step_reg,  right_step_next;
    logic [RW-1:0] row_count_reg,   row_count_next;

    logic [LW-1:0]        left_eff, right_eff;
    logic signed [LW-1:0] left_diff, right_diff;
    logic signed [LW:0]   row_diff;
    logic signed [LW:0]   row_diff_sh;
    logic [LW-1:0]        lstep;
    logic [RW-1:0]        row_eff;
    logic                 last;
    logic [LANES-1:0]     lane_on;

    assign acc      = s_tvalid && s_tready;
    assign is_shade = (ltbs_pkg::req_type_t'(s_tuser) == ltbs_pkg::REQ_SHADE);
    assign blk      = s_tdata[ltbs_pkg::BLK_LSB];
    assign tl       = s_tdata[ltbs_pkg::TL_LSB +: ltbs_pkg::CORNER_W];
    assign tr       = s_tdata[ltbs_pkg::TR_LSB +: ltbs_pkg::CORNER_W];
    assign bl       = s_tdata[ltbs_pkg::BL_LSB +: ltbs_pkg::CORNER_W];
    assign br       = s_tdata[ltbs_pkg::BR_LSB +: ltbs_pkg::CORNER_W];
    assign bs       = block_size(mip_reg);
    assign sh       = block_shift(bs);

    always_comb
    begin
        left_eff  = blk ? {2'b00, tl} : left_light_reg;
        right_eff = blk ? {2'b00, tr} : right_light_reg;

        // Corner differences fit in 16 bits, so the arithmetic shift keeps their sign.
        left_diff  = $signed({2'b00, bl}) - $signed({2'b00, tl});
        right_diff = $signed({2'b00, br}) - $signed({2'b00, tr});

        left_step_next  = blk ? LW'(left_diff >>> sh)  : left_step_reg;
        right_step_next = blk ? LW'(right_diff >>> sh) : right_step_reg;

        // Step across the row, taken from the sign-extended edge lights.
        row_diff    = $signed({left_eff[LW-1], left_eff}) - $signed({right_eff[LW-1], right_eff});
        row_diff_sh = row_diff >>> sh;
        lstep       = row_diff_sh[LW-1:0];

        left_light_next  = left_eff + left_step_next;
        right_light_next = right_eff + right_step_next;

        row_eff        = blk ? '0 : row_count_reg;
        last           = (row_eff >= (bs - RW'(1)));
        row_count_next = last ? '0 : row_eff + RW'(1);

        for (int b = 0; b < LANES; b++)
        begin
            lane_on[b] = (RW'(b) < bs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_light_reg  <= '0;
            right_light_reg <= '0;
            left_step_reg   <= '0;
            right_step_reg  <= '0;
            row_count_reg   <= '0;
        end
        else if (acc && is_shade)
        begin
            left_light_reg  <= left_light_next;
            right_light_reg <= right_light_next;
            left_step_reg   <= left_step_next;
            right_step_reg  <= right_step_next;
            row_count_reg   <= row_count_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: row start light and step
    // ---------------------------------------------------------------
    localparam int INDEX_HI_W = ltbs_pkg::INDEX_W - ltbs_pkg::BYTE_W;

    logic                s1_valid_reg;
    logic                s1_shade_reg;
    logic [ADDR_W-1:0]   s1_waddr_reg;
    logic [7:0]          s1_wdata_reg;
    logic [LW-1:0]       s1_right_reg;
    logic [LW-1:0]       s1_lstep_reg;
    logic [RW-1:0]       s1_bs_reg;
    logic [TXW-1:0]      s1_texels_reg;
    logic [LANES-1:0]    s1_on_reg;
    logic                s1_last_reg;
    logic [INDEX_HI_W-1:0] map_hi;

    assign map_hi = s_tdata[ltbs_pkg::IDX_LSB + ltbs_pkg::BYTE_W +: INDEX_HI_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_shade_reg  <= is_shade;
            s1_waddr_reg  <= {level_mod(8'(map_hi)),
                              s_tdata[ltbs_pkg::IDX_LSB +: ltbs_pkg::BYTE_W]};
            s1_wdata_reg  <= s_tdata[ltbs_pkg::VAL_LSB +: ltbs_pkg::BYTE_W];
            s1_right_reg  <= right_eff;
            s1_lstep_reg  <= lstep;
            s1_bs_reg     <= bs;
            s1_texels_reg <= s_tdata[ltbs_pkg::TXL_LSB +: TXW];
            s1_on_reg     <= lane_on;
            s1_last_reg   <= last;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: per-lane light, then colormap address and read
    // ---------------------------------------------------------------
    logic                s2_valid_reg;
    logic                s2_shade_reg;
    logic [ADDR_W-1:0]   s2_waddr_reg;
    logic [7:0]          s2_wdata_reg;
    logic [LW-1:0]       s2_light_reg [LANES];
    logic [TXW-1:0]      s2_texels_reg;
    logic [LANES-1:0]    s2_on_reg;
    logic                s2_last_reg;

    logic [LW-1:0]       lane_light [LANES];
    logic [RW-1:0]       lane_dist  [LANES];

    // Lane b sits (bs - 1 - b) steps away from the right edge light.
    always_comb
    begin
        for (int b = 0; b < LANES; b++)
        begin
            lane_dist[b]  = s1_bs_reg - RW'(1) - RW'(b);
            lane_light[b] = s1_right_reg + s1_lstep_reg * {{(LW-RW){1'b0}}, lane_dist[b]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_shade_reg  <= s1_shade_reg;
            s2_waddr_reg  <= s1_waddr_reg;
            s2_wdata_reg  <= s1_wdata_reg;
            s2_texels_reg <= s1_texels_reg;
            s2_on_reg     <= s1_on_reg;
            s2_last_reg   <= s1_last_reg;
            for (int b = 0; b < LANES; b++)
            begin
                s2_light_reg[b] <= lane_light[b];
            end
        end
    end

    // Writes and reads share this stage, so they reach every colormap
    // copy in beat order; the read port is enabled on write beats too.
    logic             map_we;
    logic [7:0]       lane_rdata [LANES];

    assign map_we = en && s2_valid_reg && !s2_shade_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [ADDR_W-1:0] raddr;

        assign raddr = {level_mod(s2_light_reg[g][LW-1:ltbs_pkg::BYTE_W]),
                        s2_texels_reg[g*ltbs_pkg::BYTE_W +: ltbs_pkg::BYTE_W]};

        ltbs_ram #(
            .WIDTH (ltbs_pkg::BYTE_W),
            .DEPTH (DEPTH)
        ) u_map (
            .clk   (clk),
            .we    (map_we),
            .waddr (s2_waddr_reg),
            .wdata (s2_wdata_reg),
            .re    (en),
            .raddr (raddr),
            .rdata (lane_rdata[g])
        );
    end

    // ---------------------------------------------------------------
    // Stage 3: colormap data, pixel assembly
    // ---------------------------------------------------------------
    logic                   s3_valid_reg;
    logic [LANES-1:0]       s3_on_reg;
    logic                   s3_last_reg;
    logic [ltbs_pkg::M_TDATA_W-1:0] pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg && s2_shade_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_on_reg   <= s2_on_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    for (genvar g = 0; g < 16; g++)
    begin : g_pix
        if (g < LANES)
        begin : g_used
            assign pix[g*8 +: 8] = s3_on_reg[g] ? lane_rdata[g] : 8'h00;
        end
        else
        begin : g_unused
            assign pix[g*8 +: 8] = 8'h00;
        end
    end

    // ---------------------------------------------------------------
    // Output register and skid register
    // ---------------------------------------------------------------
    logic                           out_valid_reg;
    logic [ltbs_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                           out_last_reg;
    logic                           skid_valid_reg;
    logic [ltbs_pkg::M_TDATA_W-1:0] skid_data_reg;
    logic                           skid_last_reg;
    logic                           out_stall;

    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign out_stall = out_valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (out_stall)
            begin
                skid_valid_reg <= s3_valid_reg;
            end
            else
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (out_stall)
            begin
                skid_data_reg <= pix;
                skid_last_reg <= s3_last_reg;
            end
            else
            begin
                out_data_reg <= pix;
                out_last_reg <= s3_last_reg;
            end
        end
        else if (m_tready)
        begin
            out_data_reg <= skid_data_reg;
            out_last_reg <= skid_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
